FILE: hdl/tcaw_pkg.sv
// Shared types and constants for the text console writer.
// Holds the character codes, parser phase codes, color palette and the
// parser result struct. No dependencies.
package tcaw_pkg;

    // Character codes the console and its escape parser react to.
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_1        = 8'h31;
    localparam logic [7:0] CH_2        = 8'h32;
    localparam logic [7:0] CH_3        = 8'h33;
    localparam logic [7:0] CH_4        = 8'h34;
    localparam logic [7:0] CH_7        = 8'h37;
    localparam logic [7:0] CH_J        = 8'h4a;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_M        = 8'h6d;

    // Escape parser phases, as reported on the result port.
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_ESC     = 3'd1;
    localparam logic [2:0] PH_BRACKET = 3'd2;
    localparam logic [2:0] PH_DIGIT   = 3'd3;
    localparam logic [2:0] PH_COLOR   = 3'd4;

    // Attribute presets.
    localparam logic [7:0] ATTR_NORMAL  = 8'h07;
    localparam logic [7:0] ATTR_BRIGHT  = 8'h0f;
    localparam logic [7:0] ATTR_REVERSE = 8'h70;

    // Next parser state together with what the top level has to do.
    typedef struct packed {
        logic       clear;      // clear the screen and home the cursor
        logic       ctrl;       // character goes to cursor handling or the screen
        logic [2:0] phase;
        logic [7:0] digit;
        logic [3:0] pending;
        logic [7:0] attr;
    } t_parse;

    // Eight entry color palette for the foreground and background selects.
    function automatic logic [3:0] palette(input logic [2:0] sel);
        logic [3:0] val;
        case (sel)
            3'd0:    val = 4'd0;
            3'd1:    val = 4'd4;
            3'd2:    val = 4'd2;
            3'd3:    val = 4'd14;
            3'd4:    val = 4'd1;
            3'd5:    val = 4'd5;
            3'd6:    val = 4'd3;
            default: val = 4'd15;
        endcase
        return val;
    endfunction

endpackage

FILE: hdl/text_console_ansi_writer.sv
// Top level of the text console writer with its screen memory.
// Instantiates tcaw_parser; depends on tcaw_pkg.
//
// The block keeps a SCREEN_ROWS x SCREEN_COLUMNS screen of 16-bit cells
// (attribute byte high, character byte low) in one synchronous memory and
// takes one item at a time: a character to put, or a request to read one
// cell. Each item ends in the S_DONE state and moves on into the output
// register once that is free; a cell read gets its data from the registered
// read port of the memory on the way. Three events walk the memory with one
// write per cycle and hold the input stalled meanwhile: the clearing pass
// after reset, the ESC [ 2 J clear and a scroll, which copies every line up
// by one with a read and a write each cycle and then zeroes the bottom line.
// The cursor is kept both as a linear cell index and as a column, so that
// line arithmetic needs no division. The output register lets the block take
// the next item while a result still waits to be taken.
module text_console_ansi_writer
    import tcaw_pkg::*;
#(
    parameter int SCREEN_ROWS    = 25,
    parameter int SCREEN_COLUMNS = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_cell_value,
    output logic [10:0] o_cursor_cell,
    output logic [7:0]  o_text_color,
    output logic [2:0]  o_escape_phase
);

    localparam int CELL_TOTAL = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int AW         = $clog2(CELL_TOTAL);
    // The cursor may run up to one line past the screen before a scroll.
    localparam int CW         = $clog2(CELL_TOTAL + SCREEN_COLUMNS);
    localparam int COLW       = $clog2(SCREEN_COLUMNS);

    localparam logic [CW-1:0]   TOTAL_C     = CW'(CELL_TOTAL);
    localparam logic [CW-1:0]   LAST_C      = CW'(CELL_TOTAL - 1);
    localparam logic [CW-1:0]   COLS_C      = CW'(SCREEN_COLUMNS);
    localparam logic [CW-1:0]   HOME_C      = CW'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
    localparam logic [COLW:0]   COLS_W      = (COLW + 1)'(SCREEN_COLUMNS);
    localparam logic [COLW-1:0] LAST_COL    = COLW'(SCREEN_COLUMNS - 1);

    typedef enum logic [2:0] {
        S_INIT,     // clearing pass after reset
        S_IDLE,     // waiting for an item
        S_SCROLL,   // copying lines up by one
        S_FILL,     // writing one value over a range of cells
        S_DONE      // result ready for the output register
    } t_state;

    // Screen memory: one write port, one registered read port.
    logic [15:0]   r_mem [CELL_TOTAL];
    logic [15:0]   r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // Control and architectural state.
    t_state        r_state, n_state;
    logic [CW-1:0] r_cur, n_cur;
    logic [COLW-1:0] r_col, n_col;
    logic [7:0]    r_attr, n_attr;
    logic [3:0]    r_pend, n_pend;
    logic [2:0]    r_phase, n_phase;
    logic [7:0]    r_digit, n_digit;
    logic [CW-1:0] r_sweep, n_sweep;
    logic [CW-1:0] r_wptr, n_wptr;
    logic          r_wr_pend, n_wr_pend;
    logic [15:0]   r_fill_data, n_fill_data;
    logic          r_is_read, n_is_read;
    logic          r_in_range, n_in_range;
    logic          r_out_valid, n_out_valid;
    logic [15:0]   r_out_cell, n_out_cell;
    logic [10:0]   r_out_cursor, n_out_cursor;
    logic [7:0]    r_out_color, n_out_color;
    logic [2:0]    r_out_phase, n_out_phase;

    t_parse        parse;
    logic          accept;
    logic          out_free;
    logic          sweep_more;

    // Cursor movement for control and ordinary characters.
    logic [CW-1:0]   cur_mv;
    logic [COLW-1:0] col_mv;
    logic            char_we;
    logic [2:0]      tab_step;
    logic [COLW:0]   tab_col;

    tcaw_parser u_parser (
        .i_char    (i_char_code),
        .i_phase   (r_phase),
        .i_digit   (r_digit),
        .i_pending (r_pend),
        .i_attr    (r_attr),
        .o_next    (parse)
    );

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign sweep_more = (r_sweep < TOTAL_C);

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cell_value   = r_out_cell;
    assign o_cursor_cell  = r_out_cursor;
    assign o_text_color   = r_out_color;
    assign o_escape_phase = r_out_phase;

    // Tab goes to the next multiple of four cells; the column wraps once at most.
    assign tab_step = 3'd4 - {1'b0, r_cur[1:0]};
    always_comb begin
        tab_col = {1'b0, r_col} + (COLW + 1)'(tab_step);
        if (tab_col >= COLS_W) begin
            tab_col = tab_col - COLS_W;
        end
    end

    always_comb begin
        cur_mv  = r_cur;
        col_mv  = r_col;
        char_we = 1'b0;
        case (i_char_code)
            CH_CR: begin
                cur_mv = r_cur - CW'(r_col);
                col_mv = '0;
            end
            CH_LF: begin
                cur_mv = r_cur + COLS_C - CW'(r_col);
                col_mv = '0;
            end
            CH_TAB: begin
                cur_mv = r_cur + CW'(tab_step);
                col_mv = tab_col[COLW-1:0];
            end
            CH_BS: begin
                // Backspace stops at the first cell of the screen.
                if (r_cur != '0) begin
                    cur_mv = r_cur - CW'(1);
                    col_mv = (r_col == '0) ? LAST_COL : r_col - COLW'(1);
                end
            end
            default: begin
                char_we = 1'b1;
                cur_mv  = r_cur + CW'(1);
                col_mv  = (r_col == LAST_COL) ? '0 : r_col + COLW'(1);
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_col        = r_col;
        n_attr       = r_attr;
        n_pend       = r_pend;
        n_phase      = r_phase;
        n_digit      = r_digit;
        n_sweep      = r_sweep;
        n_wptr       = r_wptr;
        n_wr_pend    = r_wr_pend;
        n_fill_data  = r_fill_data;
        n_is_read    = r_is_read;
        n_in_range   = r_in_range;
        n_out_valid  = r_out_valid;
        n_out_cell   = r_out_cell;
        n_out_cursor = r_out_cursor;
        n_out_color  = r_out_color;
        n_out_phase  = r_out_phase;
        mem_we       = 1'b0;
        mem_waddr    = r_wptr[AW-1:0];
        mem_wdata    = r_fill_data;
        mem_re       = 1'b0;
        mem_raddr    = r_sweep[AW-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_wptr    = r_wptr + CW'(1);
                if (r_wptr == LAST_C) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_action) begin
                        // Cell read: state is kept, data arrives next cycle.
                        n_is_read  = 1'b1;
                        n_in_range = (32'(i_cell_index) < 32'(CELL_TOTAL));
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(i_cell_index);
                        n_state    = S_DONE;
                    end else begin
                        n_is_read = 1'b0;
                        n_phase   = parse.phase;
                        n_digit   = parse.digit;
                        n_pend    = parse.pending;
                        n_attr    = parse.attr;
                        n_state   = S_DONE;
                        if (parse.clear) begin
                            n_cur       = '0;
                            n_col       = '0;
                            n_wptr      = '0;
                            n_fill_data = {r_attr, CH_SPACE};
                            n_state     = S_FILL;
                        end else if (parse.ctrl) begin
                            mem_we    = char_we;
                            mem_waddr = r_cur[AW-1:0];
                            mem_wdata = {r_attr, i_char_code};
                            n_cur     = cur_mv;
                            n_col     = col_mv;
                            if (cur_mv >= TOTAL_C) begin
                                // Past the last line: scroll up by one line.
                                n_cur     = cur_mv - COLS_C;
                                n_sweep   = COLS_C;
                                n_wptr    = '0;
                                n_wr_pend = 1'b0;
                                n_state   = S_SCROLL;
                            end
                        end
                    end
                end
            end
            S_SCROLL: begin
                // Read cell i in one cycle, write it to cell i minus one line
                // in the next; the two addresses never meet.
                if (sweep_more) begin
                    mem_re  = 1'b1;
                    n_sweep = r_sweep + CW'(1);
                end
                if (r_wr_pend) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata;
                    n_wptr    = r_wptr + CW'(1);
                end
                n_wr_pend = sweep_more;
                if (!sweep_more && r_wr_pend) begin
                    // The write pointer now stands at the bottom line.
                    n_fill_data = '0;
                    n_state     = S_FILL;
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                n_wptr = r_wptr + CW'(1);
                if (r_wptr == LAST_C) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_cell   = (r_is_read && r_in_range) ? r_rdata : '0;
                    n_out_cursor = 11'(r_cur);
                    n_out_color  = r_attr;
                    n_out_phase  = r_phase;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_cur        <= HOME_C;
            r_col        <= '0;
            r_attr       <= ATTR_NORMAL;
            r_pend       <= '0;
            r_phase      <= PH_IDLE;
            r_digit      <= '0;
            r_sweep      <= '0;
            r_wptr       <= '0;
            r_wr_pend    <= 1'b0;
            r_fill_data  <= '0;
            r_is_read    <= 1'b0;
            r_in_range   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_col        <= n_col;
            r_attr       <= n_attr;
            r_pend       <= n_pend;
            r_phase      <= n_phase;
            r_digit      <= n_digit;
            r_sweep      <= n_sweep;
            r_wptr       <= n_wptr;
            r_wr_pend    <= n_wr_pend;
            r_fill_data  <= n_fill_data;
            r_is_read    <= n_is_read;
            r_in_range   <= n_in_range;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_out_cell   <= n_out_cell;
        r_out_cursor <= n_out_cursor;
        r_out_color  <= n_out_color;
        r_out_phase  <= n_out_phase;
    end

    // Screen memory ports.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

endmodule

FILE: hdl/tcaw_parser.sv
// Escape sequence decoder of the text console writer.
// Computes the next parser state and attribute for one character.
// Depends on tcaw_pkg.
module tcaw_parser
    import tcaw_pkg::*;
(
    input  logic [7:0] i_char,
    input  logic [2:0] i_phase,
    input  logic [7:0] i_digit,
    input  logic [3:0] i_pending,
    input  logic [7:0] i_attr,
    output t_parse     o_next
);

    logic consumed;
    logic is_oct_digit;

    assign is_oct_digit = (i_char[7:3] == CH_0[7:3]);

    always_comb begin
        consumed        = 1'b0;
        o_next.clear    = 1'b0;
        o_next.ctrl     = 1'b0;
        o_next.phase    = i_phase;
        o_next.digit    = i_digit;
        o_next.pending  = i_pending;
        o_next.attr     = i_attr;
        case (i_phase)
            PH_ESC: begin
                if (i_char == CH_LBRACKET) begin
                    o_next.phase = PH_BRACKET;
                    consumed     = 1'b1;
                end
            end
            PH_BRACKET: begin
                if (i_char == CH_0 || i_char == CH_1 || i_char == CH_2 ||
                    i_char == CH_3 || i_char == CH_4 || i_char == CH_7) begin
                    o_next.phase = PH_DIGIT;
                    o_next.digit = i_char;
                    consumed     = 1'b1;
                end
            end
            PH_DIGIT: begin
                if (is_oct_digit) begin
                    if (i_digit == CH_3 || i_digit == CH_4) begin
                        o_next.pending = palette(i_char[2:0]);
                        o_next.phase   = PH_COLOR;
                        consumed       = 1'b1;
                    end
                end else if (i_char == CH_J) begin
                    if (i_digit == CH_2) begin
                        o_next.clear = 1'b1;
                        o_next.phase = PH_IDLE;
                        consumed     = 1'b1;
                    end
                end else if (i_char == CH_M) begin
                    if (i_digit == CH_0) begin
                        o_next.attr  = ATTR_NORMAL;
                        o_next.phase = PH_IDLE;
                        consumed     = 1'b1;
                    end else if (i_digit == CH_1) begin
                        o_next.attr  = ATTR_BRIGHT;
                        o_next.phase = PH_IDLE;
                        consumed     = 1'b1;
                    end else if (i_digit == CH_7) begin
                        o_next.attr  = ATTR_REVERSE;
                        o_next.phase = PH_IDLE;
                        consumed     = 1'b1;
                    end
                end
            end
            PH_COLOR: begin
                if (i_char == CH_M && i_digit == CH_3) begin
                    o_next.attr  = {i_attr[7:4], i_pending};
                    o_next.phase = PH_IDLE;
                    consumed     = 1'b1;
                end else if (i_char == CH_M && i_digit == CH_4) begin
                    o_next.attr  = {i_pending, i_attr[3:0]};
                    o_next.phase = PH_IDLE;
                    consumed     = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // A character that does not fit the sequence ends it and is then
        // treated as an ordinary one; an escape starts a new sequence.
        if (!consumed) begin
            if (i_char == CH_ESC) begin
                o_next.phase = PH_ESC;
            end else begin
                o_next.phase = PH_IDLE;
                o_next.ctrl  = 1'b1;
            end
        end
    end

endmodule

FILE: hdl/tcaw_checks.sv
// Port level checks for the text console writer, bound to its top level.
// Watches the handshakes and result fields only; depends on no package.
module tcaw_checks #(
    parameter int CELL_TOTAL = 2000
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_cell_value,
    input logic [10:0] o_cursor_cell,
    input logic [7:0]  o_text_color,
    input logic [2:0]  o_escape_phase
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_open;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Items accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 2'(in_acc) - 2'(out_acc);
        end
    end

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input accepted while an item was still being worked on");

    // A result only ever follows an accepted item.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_open != 2'd0)
        else $error("result shown without an accepted item");

    // At most one item in work and one waiting in the output register.
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= 2'd2)
        else $error("more items outstanding than the block can hold");

    // Reported cursor and parser phase stay in their ranges.
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_escape_phase <= 3'd4) &&
                        (32'(o_cursor_cell) < 32'(CELL_TOTAL) || CELL_TOTAL > 2048))
        else $error("cursor or parser phase out of range");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cell_value) &&
            $stable(o_cursor_cell) && $stable(o_text_color) && $stable(o_escape_phase))
        else $error("stalled result changed");

endmodule

bind text_console_ansi_writer tcaw_checks #(
    .CELL_TOTAL (SCREEN_ROWS * SCREEN_COLUMNS)
) u_tcaw_checks (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_cell_value   (o_cell_value),
    .o_cursor_cell  (o_cursor_cell),
    .o_text_color   (o_text_color),
    .o_escape_phase (o_escape_phase)
);

FILE: sim/text_console_ansi_writer_tb.sv
// Self-checking testbench for text_console_ansi_writer.
// Predicts each result with its own screen and escape parser and compares every field.
// Depends on tcaw_pkg and the text_console_ansi_writer RTL.
`timescale 1ns / 100ps

module text_console_ansi_writer_tb;
    import tcaw_pkg::*;

    localparam int ROWS       = 25;
    localparam int COLS       = 80;
    localparam int CELL_COUNT = ROWS * COLS;

    // Item kinds on the input channel.
    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Foreground and background choices selected by the digit after 3 or 4.
    localparam logic [3:0] COLOR_MAP [0:7] = '{4'd0, 4'd4, 4'd2, 4'd14,
                                               4'd1, 4'd5, 4'd3, 4'd15};

    typedef struct packed {
        logic [15:0] cell_val;
        logic [10:0] cursor;
        logic [7:0]  color;
        logic [2:0]  phase;
    } t_console_result;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_action = ACT_PUT;
    logic [7:0]  in_char   = 8'h00;
    logic [10:0] in_index  = 11'd0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [15:0] out_cell;
    logic [10:0] out_cursor;
    logic [7:0]  out_color;
    logic [2:0]  out_phase;

    // Predicted console state: screen contents, cursor, colors and parser.
    logic [15:0] screen_model [0:CELL_COUNT-1];
    int          cur_cell;
    logic [7:0]  cur_attr;
    logic [3:0]  held_color;
    logic [2:0]  esc_phase;
    logic [7:0]  esc_digit;

    t_console_result awaited_results [$];

    bit failed         = 1'b0;
    bit in_idle_on     = 1'b1;
    bit out_idle_on    = 1'b1;
    int hold_cycles    = 0;
    int accepted_items = 0;

    text_console_ansi_writer #(
        .SCREEN_ROWS    (ROWS),
        .SCREEN_COLUMNS (COLS)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_action       (in_action),
        .i_char_code    (in_char),
        .i_cell_index   (in_index),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_cell_value   (out_cell),
        .o_cursor_cell  (out_cursor),
        .o_text_color   (out_color),
        .o_escape_phase (out_phase)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Console predictor
    // ------------------------------------------------------------------

    // State right after reset: a blank screen, the cursor at the start of the
    // bottom line and the normal attribute.
    function automatic void console_reset();
        int k;
        for (k = 0; k < CELL_COUNT; k++) screen_model[k] = 16'h0000;
        cur_cell   = (ROWS - 1) * COLS;
        cur_attr   = ATTR_NORMAL;
        held_color = 4'd0;
        esc_phase  = PH_IDLE;
        esc_digit  = 8'h00;
    endfunction

    // ESC [ 2 J fills every cell with a space in the current color.
    function automatic void wipe_screen();
        int k;
        for (k = 0; k < CELL_COUNT; k++) screen_model[k] = {cur_attr, CH_SPACE};
        cur_cell  = 0;
        esc_phase = PH_IDLE;
    endfunction

    // Advances the escape parser. Returns 1 when the character belongs to the
    // running sequence; otherwise the caller treats it as an ordinary character,
    // which also ends any sequence in progress.
    function automatic bit escape_consumes(input logic [7:0] ch);
        case (esc_phase)
            PH_ESC: begin
                if (ch == CH_LBRACKET) begin
                    esc_phase = PH_BRACKET;
                    return 1'b1;
                end
            end
            PH_BRACKET: begin
                if (ch == CH_0 || ch == CH_1 || ch == CH_2 || ch == CH_3 ||
                    ch == CH_4 || ch == CH_7) begin
                    esc_phase = PH_DIGIT;
                    esc_digit = ch;
                    return 1'b1;
                end
            end
            PH_DIGIT: begin
                if (ch >= CH_0 && ch <= CH_7) begin
                    // A second digit only fits after 3 or 4.
                    if (esc_digit == CH_3 || esc_digit == CH_4) begin
                        held_color = COLOR_MAP[ch[2:0]];
                        esc_phase  = PH_COLOR;
                        return 1'b1;
                    end
                end else if (ch == CH_J) begin
                    if (esc_digit == CH_2) begin
                        wipe_screen();
                        return 1'b1;
                    end
                end else if (ch == CH_M) begin
                    if (esc_digit == CH_0) begin
                        cur_attr  = ATTR_NORMAL;
                        esc_phase = PH_IDLE;
                        return 1'b1;
                    end
                    if (esc_digit == CH_1) begin
                        cur_attr  = ATTR_BRIGHT;
                        esc_phase = PH_IDLE;
                        return 1'b1;
                    end
                    if (esc_digit == CH_7) begin
                        cur_attr  = ATTR_REVERSE;
                        esc_phase = PH_IDLE;
                        return 1'b1;
                    end
                end
            end
            PH_COLOR: begin
                if (ch == CH_M && esc_digit == CH_3) begin
                    cur_attr  = {cur_attr[7:4], held_color};
                    esc_phase = PH_IDLE;
                    return 1'b1;
                end
                if (ch == CH_M && esc_digit == CH_4) begin
                    cur_attr  = {held_color, cur_attr[3:0]};
                    esc_phase = PH_IDLE;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void console_put(input logic [7:0] ch);
        int k;
        if (escape_consumes(ch)) return;
        case (ch)
            CH_ESC: begin
                esc_phase = PH_ESC;
                return;
            end
            CH_CR:   cur_cell = cur_cell - cur_cell % COLS;
            CH_LF:   cur_cell = cur_cell + COLS - cur_cell % COLS;
            CH_TAB:  cur_cell = cur_cell + 4 - cur_cell % 4;
            CH_BS:   if (cur_cell > 0) cur_cell = cur_cell - 1;
            default: begin
                if (cur_cell < CELL_COUNT) screen_model[cur_cell] = {cur_attr, ch};
                cur_cell = cur_cell + 1;
            end
        endcase
        esc_phase = PH_IDLE;
        // Running off the bottom scrolls one line up and blanks the last line.
        if (cur_cell >= CELL_COUNT) begin
            for (k = COLS; k < CELL_COUNT; k++) screen_model[k - COLS] = screen_model[k];
            for (k = CELL_COUNT - COLS; k < CELL_COUNT; k++) screen_model[k] = 16'h0000;
            cur_cell = cur_cell - COLS;
        end
    endfunction

    // Applies one accepted item and queues the result it must produce.
    function automatic void console_step(input logic act, input logic [7:0] ch,
                                         input logic [10:0] idx);
        t_console_result res;
        res.cell_val = 16'h0000;
        if (act == ACT_PUT) begin
            console_put(ch);
        end else if (idx < CELL_COUNT) begin
            res.cell_val = screen_model[idx];
        end
        res.cursor = cur_cell[10:0];
        res.color  = cur_attr;
        res.phase  = esc_phase;
        awaited_results.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one item and returns at the edge where it was accepted. Valid stays
    // high on return so that a following item can go back to back; anyone who
    // pauses the sender lowers it through wait_drained.
    task automatic send_item(input logic act, input logic [7:0] ch, input logic [10:0] idx);
        while (in_idle_on && $urandom_range(99) < 38) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_char   <= ch;
        in_index  <= idx;
        do @(posedge clk); while (in_stall !== 1'b0);
        console_step(act, ch, idx);
        accepted_items++;
    endtask

    // The unused field of each item carries random bits as well.
    task automatic send_put(input logic [7:0] ch);
        send_item(ACT_PUT, ch, 11'($urandom_range(2047)));
    endtask

    task automatic send_read(input logic [10:0] idx);
        send_item(ACT_READ, 8'($urandom_range(255)), idx);
    endtask

    // Stops offering items and waits until every queued result has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
    endtask

    // Read addresses favor the cell just written, with a share past the screen.
    function automatic logic [10:0] pick_cell_index();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 11'($urandom_range(2047, CELL_COUNT));
        if (r < 40) return 11'((cur_cell > 0) ? cur_cell - 1 : 0);
        return 11'($urandom_range(CELL_COUNT - 1));
    endfunction

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // The receiver stalls at random, or solidly while a hold-off is counting down.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                hold_cycles--;
            end else if (out_idle_on) begin
                out_stall <= ($urandom_range(99) < 38);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Every accepted result is matched against the oldest prediction.
    always @(posedge clk) begin
        t_console_result want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("result with nothing expected: cell_value %h cursor_cell %0d",
                       out_cell, out_cursor);
                failed = 1'b1;
            end else begin
                want = awaited_results.pop_front();
                if (out_cell !== want.cell_val) begin
                    $error("cell_value: expected %h, got %h", want.cell_val, out_cell);
                    failed = 1'b1;
                end
                if (out_cursor !== want.cursor) begin
                    $error("cursor_cell: expected %0d, got %0d", want.cursor, out_cursor);
                    failed = 1'b1;
                end
                if (out_color !== want.color) begin
                    $error("text_color: expected %h, got %h", want.color, out_color);
                    failed = 1'b1;
                end
                if (out_phase !== want.phase) begin
                    $error("escape_phase: expected %0d, got %0d", want.phase, out_phase);
                    failed = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The screen must be blank after the clearing pass, including a read that
    // lies past the end of the screen with every address bit set.
    task automatic test_reset_contents();
        send_read(11'd0);
        send_read(11'd2047);
    endtask

    // Ordinary characters at both ends of the byte range, then each cursor
    // control. The line feed on the bottom line forces a scroll, after which
    // the written line must show up one line higher.
    task automatic test_cursor_controls();
        send_put(8'h41);
        send_put(8'hff);
        send_put(8'h00);
        send_put(CH_TAB);
        send_put(CH_BS);
        send_put(CH_CR);
        send_put(CH_LF);
        send_read(11'((ROWS - 2) * COLS));
        send_read(11'(CELL_COUNT - 1));
    endtask

    // A full clear, backspace stuck at the home position, a foreground and a
    // bright sequence, and an escape followed by a character that does not fit.
    task automatic test_escape_directed();
        send_put(CH_ESC);
        send_put(CH_LBRACKET);
        send_put(CH_2);
        send_put(CH_J);
        send_put(CH_BS);
        send_put(CH_ESC);
        send_put(CH_LBRACKET);
        send_put(CH_3);
        send_put(CH_0 + 8'd5);
        send_put(CH_M);
        send_put(CH_ESC);
        send_put(CH_LBRACKET);
        send_put(CH_1);
        send_put(CH_M);
        send_put(CH_ESC);
        send_put(8'h58);
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the block fills and has to stall its input.
    task automatic test_output_backpressure();
        int k;
        hold_cycles = 400;
        for (k = 0; k < 30; k++) send_put(8'($urandom_range(8'h20, 8'h7e)));
        wait_drained();
    endtask

    // Mostly printable text with an occasional control character. Line feeds
    // are kept rare because each scroll walks the whole screen.
    task automatic send_text_run(input int len);
        int k;
        int r;
        for (k = 0; k < len; k++) begin
            r = $urandom_range(99);
            if (r < 2)       send_put(CH_LF);
            else if (r < 5)  send_put(CH_CR);
            else if (r < 9)  send_put(CH_TAB);
            else if (r < 13) send_put(CH_BS);
            else if (r < 20) send_put(8'($urandom_range(8'h80, 8'hff)));
            else             send_put(8'($urandom_range(8'h20, 8'h7e)));
        end
    endtask

    // A well-formed sequence of a random kind. About one in four is broken by
    // a near miss at a random position and sometimes cut short there; reads
    // are slipped in between the characters since they must not disturb the parser.
    task automatic send_escape_sequence();
        logic [7:0] seq [$];
        int r;
        int k;
        int j;
        int len;
        r = $urandom_range(99);
        seq.push_back(CH_ESC);
        seq.push_back(CH_LBRACKET);
        if (r < 6) begin
            seq.push_back(CH_2);
            seq.push_back(CH_J);
        end else if (r < 35) begin
            case ($urandom_range(2))
                0:       seq.push_back(CH_0);
                1:       seq.push_back(CH_1);
                default: seq.push_back(CH_7);
            endcase
            seq.push_back(CH_M);
        end else begin
            seq.push_back((r < 65) ? CH_3 : CH_4);
            seq.push_back(CH_0 + 8'($urandom_range(7)));
            seq.push_back(CH_M);
        end
        len = seq.size();
        if ($urandom_range(99) < 25) begin
            k = $urandom_range(1, seq.size() - 1);
            case ($urandom_range(7))
                0:       seq[k] = CH_J;
                1:       seq[k] = CH_M;
                2:       seq[k] = CH_ESC;
                3:       seq[k] = CH_LBRACKET;
                4:       seq[k] = CH_0 + 8'($urandom_range(9));
                5:       seq[k] = CH_LF;
                default: seq[k] = 8'($urandom_range(255));
            endcase
            if ($urandom_range(1) == 1) len = k + 1;
        end
        for (j = 0; j < len; j++) begin
            if ($urandom_range(99) < 8) send_read(pick_cell_index());
            send_put(seq[j]);
        end
    endtask

    task automatic test_random_traffic(input int item_goal);
        int stop_at;
        int pick;
        stop_at = accepted_items + item_goal;
        while (accepted_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45)      send_text_run($urandom_range(1, 30));
            else if (pick < 70) send_escape_sequence();
            else if (pick < 90) send_read(pick_cell_index());
            else                send_put(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial begin
        console_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_contents();
        test_cursor_controls();
        test_escape_directed();
        test_output_backpressure();

        // Random traffic in three stretches; the middle one runs without any
        // idling on either side, and the sender drains between stretches.
        test_random_traffic(500);
        wait_drained();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        test_random_traffic(300);
        wait_drained();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        test_random_traffic(500);
        wait_drained();

        // Leave room for a scroll or clear still in progress to show any
        // stray result.
        out_idle_on = 1'b0;
        repeat (2100) @(posedge clk);
        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("[text_console_ansi_writer] OK");
        end else begin
            $display("[text_console_ansi_writer] ERROR");
        end
        $finish;
    end

    // Generous limit: a few hundred scrolls and clears, each walking the whole
    // screen, plus every item waiting out gaps and stalls, fit many times over.
    initial begin
        #(20_000_000);
        $display("[text_console_ansi_writer] ERROR");
        $finish;
    end

endmodule
